// File: rtl/rkc_pkg.sv
// ----------------------------------------------------------------------------
// rkc_pkg
// Shared types, codes, constants and helper functions for the disk cartridge
// controller.
// ----------------------------------------------------------------------------
package rkc_pkg;

    // Geometry and drive limits
    localparam int NUM_DRIVES       = 4;
    localparam int DRIVE_SLOTS      = 4;
    localparam int SLOT_W           = $clog2(DRIVE_SLOTS);
    localparam int WORDS_PER_SECTOR = 256;
    localparam int MAX_CYLINDER     = 202;
    localparam int MAX_SECTOR       = 11;
    localparam int SECTORS_PER_SURF = MAX_SECTOR + 1;
    localparam int SECTORS_PER_CYL  = 2 * SECTORS_PER_SURF;

    // Register constants
    localparam logic [15:0] CS_WRITABLE  = 16'o17517;
    localparam logic [15:0] CS_GO        = 16'o1;
    localparam logic [15:0] STATUS_RESET = 16'o4300;
    localparam logic [15:0] CTL_RESET    = 16'o200;
    localparam logic [15:0] CTL_ERRBITS  = 16'o140000;
    localparam logic [15:0] ST_WRLOCK    = 16'o40;
    localparam logic [15:0] ER_NXS       = 16'o40;
    localparam logic [15:0] ER_NXC       = 16'o100;
    localparam logic [15:0] ER_NXD       = 16'o200;

    // Bit positions
    localparam int ST_READY_BIT = 6;
    localparam int CT_READY_BIT = 7;
    localparam int CT_IE_BIT    = 6;

    // Request function codes
    typedef enum logic [1:0] {
        FUNC_READ  = 2'd0,
        FUNC_WRITE = 2'd1,
        FUNC_XFER  = 2'd2
    } func_t;

    // Register selectors
    typedef enum logic [2:0] {
        SEL_STATUS  = 3'd0,
        SEL_ERROR   = 3'd1,
        SEL_CONTROL = 3'd2,
        SEL_WCOUNT  = 3'd3,
        SEL_BUSADDR = 3'd4,
        SEL_DISKADR = 3'd5
    } sel_t;

    // Control register function field
    typedef enum logic [2:0] {
        CMD_CTL_RESET   = 3'd0,
        CMD_WRITE       = 3'd1,
        CMD_READ        = 3'd2,
        CMD_SEEK        = 3'd3,
        CMD_WRITE_CHECK = 3'd4,
        CMD_READ_CHECK  = 3'd5,
        CMD_DRV_RESET   = 3'd6,
        CMD_WRITE_LOCK  = 3'd7
    } cmd_t;

    // Disk address, laid out as in the disk address register
    typedef struct packed {
        logic [2:0] drive;
        logic [7:0] cyl;
        logic       surf;
        logic [3:0] sec;
    } da_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [2:0]  reg_sel;
        logic [15:0] data_in;
    } req_t;

    typedef struct packed {
        logic [15:0] rd_data;
        logic [17:0] mem_addr;
        logic [12:0] disk_sector;
        logic [7:0]  disk_word;
        logic [15:0] xfer_data;
        logic        xfer_valid;
        logic        xfer_to_memory;
        logic        ready_res;
        logic        irq;
        logic        error;
    } rsp_t;

    // Engine status seen by the top level
    typedef struct packed {
        logic busy;
        logic ctl_ready;
    } stat_t;

    // Step sector, then surface, then cylinder
    function automatic da_t da_advance(da_t a);
        da_t r;
        r = a;
        if (a.sec >= 4'(MAX_SECTOR)) begin
            r.sec  = '0;
            r.surf = ~a.surf;
            if (a.surf)
                r.cyl = a.cyl + 8'd1;
        end
        else begin
            r.sec = a.sec + 4'd1;
        end
        return r;
    endfunction

    // Drive number within a valid slot
    function automatic logic drive_ok(logic [2:0] drive);
        return (int'(drive) < DRIVE_SLOTS) && (int'(drive) < NUM_DRIVES);
    endfunction

    // Address check: error bits, zero when the address is good
    function automatic logic [15:0] da_check(da_t a, logic [DRIVE_SLOTS-1:0] attached);
        logic present;
        present = drive_ok(a.drive) && attached[a.drive[SLOT_W-1:0]];
        if (!present)
            return ER_NXD;
        else if (int'(a.cyl) > MAX_CYLINDER)
            return ER_NXC;
        else if (int'(a.sec) > MAX_SECTOR)
            return ER_NXS;
        else
            return '0;
    endfunction

endpackage

// File: rtl/rkc_if.sv
// ----------------------------------------------------------------------------
// rkc_req_if / rkc_rsp_if
// Valid/ready channels for controller requests and results.
// ----------------------------------------------------------------------------
interface rkc_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [2:0]  reg_sel;
    logic [15:0] data_in;

    modport source (output valid, output func, output reg_sel, output data_in, input ready);
    modport sink   (input valid, input func, input reg_sel, input data_in, output ready);
endinterface

interface rkc_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] rd_data;
    logic [17:0] mem_addr;
    logic [12:0] disk_sector;
    logic [7:0]  disk_word;
    logic [15:0] xfer_data;
    logic        xfer_valid;
    logic        xfer_to_memory;
    logic        ready_res;
    logic        irq;
    logic        error;

    modport source (output valid, output rd_data, output mem_addr, output disk_sector,
                    output disk_word, output xfer_data, output xfer_valid,
                    output xfer_to_memory, output ready_res, output irq, output error,
                    input ready);
    modport sink   (input valid, input rd_data, input mem_addr, input disk_sector,
                    input disk_word, input xfer_data, input xfer_valid,
                    input xfer_to_memory, input ready_res, input irq, input error,
                    output ready);
endinterface

// File: rtl/rkc_engine.sv
// ----------------------------------------------------------------------------
// rkc_engine
// Controller register file and the next-state update for one request.
// ----------------------------------------------------------------------------
module rkc_engine
    import rkc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [3:0]       cfg_wr_data,
    input  logic             step_en,
    input  req_t             item,
    output rsp_t             res,
    output stat_t            stat
);

    // Controller state
    logic [DRIVE_SLOTS-1:0] attached_reg;
    logic [17:0]            ba_reg, ba_next;
    logic [15:0]            st_reg, st_next;
    logic [15:0]            er_reg, er_next;
    logic [15:0]            ct_reg, ct_next;
    logic [15:0]            wc_reg, wc_next;
    da_t                    da_reg, da_next;
    logic [DRIVE_SLOTS-1:0] wl_reg, wl_next;
    logic [8:0]             wis_reg, wis_next;
    logic                   busy_reg, busy_next;

    // Scratch for the update
    logic [15:0] chk;
    logic [15:0] vm;
    logic [15:0] wc_inc;
    logic [8:0]  wis_inc;
    da_t         da_adv;
    logic        locked;

    assign locked = drive_ok(da_reg.drive) && wl_reg[da_reg.drive[SLOT_W-1:0]];

    // Next state and result for the request
    always_comb
    begin
        ba_next   = ba_reg;
        st_next   = st_reg;
        er_next   = er_reg;
        ct_next   = ct_reg;
        wc_next   = wc_reg;
        da_next   = da_reg;
        wl_next   = wl_reg;
        wis_next  = wis_reg;
        busy_next = busy_reg;
        res       = '0;
        chk       = '0;
        vm        = '0;
        wc_inc    = wc_reg + 16'd1;
        wis_inc   = wis_reg + 9'd1;
        da_adv    = da_advance(da_reg);

        case (item.func)
            FUNC_READ:
            begin
                case (item.reg_sel)
                    SEL_STATUS:  res.rd_data = st_reg | (locked ? ST_WRLOCK : 16'd0);
                    SEL_ERROR:   res.rd_data = er_reg;
                    SEL_CONTROL: res.rd_data = ct_reg | {10'd0, ba_reg[17:16], 4'd0};
                    SEL_WCOUNT:  res.rd_data = wc_reg;
                    SEL_BUSADDR: res.rd_data = ba_reg[15:0];
                    SEL_DISKADR: res.rd_data = da_reg;
                    default:     res.rd_data = '0;
                endcase
            end
            FUNC_WRITE:
            begin
                case (item.reg_sel)
                    SEL_CONTROL:
                    begin
                        // abort any transfer, take the writable bits
                        busy_next = 1'b0;
                        ba_next   = {item.data_in[5:4], ba_reg[15:0]};
                        vm        = item.data_in & CS_WRITABLE;
                        ct_next   = (ct_reg & ~CS_WRITABLE) | (vm & ~CS_GO);
                        if (vm[0])
                        begin
                            case (cmd_t'(ct_next[3:1]))
                                CMD_CTL_RESET, CMD_DRV_RESET:
                                begin
                                    st_next  = STATUS_RESET;
                                    ct_next  = CTL_RESET;
                                    er_next  = '0;
                                    wc_next  = '0;
                                    ba_next  = '0;
                                    wis_next = '0;
                                end
                                CMD_WRITE_LOCK:
                                begin
                                    if (drive_ok(da_reg.drive))
                                        wl_next[da_reg.drive[SLOT_W-1:0]] = 1'b1;
                                    st_next[ST_READY_BIT] = 1'b1;
                                    ct_next[CT_READY_BIT] = 1'b1;
                                    res.irq = ct_next[CT_IE_BIT];
                                end
                                CMD_WRITE, CMD_READ:
                                begin
                                    st_next[ST_READY_BIT] = 1'b0;
                                    ct_next[CT_READY_BIT] = 1'b0;
                                    chk = da_check(da_reg, attached_reg);
                                    if (chk != '0)
                                    begin
                                        st_next[ST_READY_BIT] = 1'b1;
                                        ct_next[CT_READY_BIT] = 1'b1;
                                        er_next   = er_reg | chk;
                                        ct_next   = ct_next | CTL_ERRBITS;
                                        res.irq   = ct_next[CT_IE_BIT];
                                        res.error = 1'b1;
                                    end
                                    else
                                    begin
                                        wis_next = '0;
                                        if (wc_reg == '0)
                                        begin
                                            da_next = da_adv;
                                            st_next[ST_READY_BIT] = 1'b1;
                                            ct_next[CT_READY_BIT] = 1'b1;
                                            res.irq = ct_next[CT_IE_BIT];
                                        end
                                        else
                                        begin
                                            busy_next = 1'b1;
                                        end
                                    end
                                end
                                default:
                                begin
                                end
                            endcase
                        end
                    end
                    SEL_WCOUNT:  wc_next = item.data_in;
                    SEL_BUSADDR: ba_next = {ba_reg[17:16], item.data_in};
                    SEL_DISKADR: da_next = da_t'(item.data_in);
                    default:
                    begin
                    end
                endcase
            end
            FUNC_XFER:
            begin
                if (busy_reg)
                begin
                    if (wc_reg == '0)
                    begin
                        busy_next = 1'b0;
                        st_next[ST_READY_BIT] = 1'b1;
                        ct_next[CT_READY_BIT] = 1'b1;
                        res.irq = ct_reg[CT_IE_BIT];
                    end
                    else
                    begin
                        // move one word at the current position
                        res.xfer_valid     = 1'b1;
                        res.xfer_data      = item.data_in;
                        res.xfer_to_memory = (cmd_t'(ct_reg[3:1]) == CMD_READ);
                        res.mem_addr       = ba_reg;
                        res.disk_sector    = 13'(da_reg.cyl) * 13'(SECTORS_PER_CYL)
                                           + (da_reg.surf ? 13'(SECTORS_PER_SURF) : 13'd0)
                                           + 13'(da_reg.sec);
                        res.disk_word      = wis_reg[7:0];
                        ba_next            = ba_reg + 18'd2;
                        wc_next            = wc_inc;
                        wis_next           = wis_inc;
                        // end of sector or of transfer
                        if ((10'(wis_inc) >= 10'(WORDS_PER_SECTOR)) || (wc_inc == '0))
                        begin
                            wis_next = '0;
                            da_next  = da_adv;
                            if (wc_inc == '0)
                            begin
                                busy_next = 1'b0;
                                st_next[ST_READY_BIT] = 1'b1;
                                ct_next[CT_READY_BIT] = 1'b1;
                                res.irq = ct_reg[CT_IE_BIT];
                            end
                            else
                            begin
                                chk = da_check(da_adv, attached_reg);
                                if (chk != '0)
                                begin
                                    busy_next = 1'b0;
                                    st_next[ST_READY_BIT] = 1'b1;
                                    ct_next = ct_reg | CTL_ERRBITS | CTL_RESET;
                                    er_next = er_reg | chk;
                                    res.irq   = ct_reg[CT_IE_BIT];
                                    res.error = 1'b1;
                                end
                            end
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase

        res.ready_res = ct_next[CT_READY_BIT];
    end

    // Drive attach register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            attached_reg <= '0;
        else if (cfg_wr_en)
            attached_reg <= cfg_wr_data[DRIVE_SLOTS-1:0];
    end

    // State registers, updated as each request is processed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ba_reg   <= '0;
            st_reg   <= STATUS_RESET;
            er_reg   <= '0;
            ct_reg   <= CTL_RESET;
            wc_reg   <= '0;
            da_reg   <= '0;
            wl_reg   <= '0;
            wis_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else if (step_en)
        begin
            ba_reg   <= ba_next;
            st_reg   <= st_next;
            er_reg   <= er_next;
            ct_reg   <= ct_next;
            wc_reg   <= wc_next;
            da_reg   <= da_next;
            wl_reg   <= wl_next;
            wis_reg  <= wis_next;
            busy_reg <= busy_next;
        end
    end

    assign stat.busy      = busy_reg;
    assign stat.ctl_ready = ct_reg[CT_READY_BIT];

endmodule

// File: rtl/disk_cartridge_controller_unit.sv
// Order: a request is captured in the input register, then processed into the
// result register when that register has room, and offered from there.
// Throughput: one request per cycle; the single state-update stage between the
// input and result registers sets the rate, stalls only on result backpressure.
// Reset (rst_n low, asynchronous): registers take their power-on values, drive
// attach mask and write locks cleared, both pipeline registers empty.
// ----------------------------------------------------------------------------
// disk_cartridge_controller_unit
// Top level: input register, controller engine and result register.
// ----------------------------------------------------------------------------
module disk_cartridge_controller_unit
    import rkc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wr_en,
    input  logic [3:0]   cfg_wr_data,
    rkc_req_if.sink      req,
    rkc_rsp_if.source    rsp
);

    logic  in_vld_reg;
    req_t  in_item_reg;
    logic  out_vld_reg;
    rsp_t  out_res_reg;
    logic  advance;
    rsp_t  step_res;
    stat_t stat;

    // Move the held request into the result register when it has room
    assign advance   = in_vld_reg && (!out_vld_reg || rsp.ready);
    assign req.ready = !in_vld_reg || advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (req.ready)
            in_vld_reg <= req.valid;
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
            in_item_reg <= '{func: req.func, reg_sel: req.reg_sel, data_in: req.data_in};
    end

    rkc_engine u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .step_en     (advance),
        .item        (in_item_reg),
        .res         (step_res),
        .stat        (stat)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (advance)
            out_vld_reg <= 1'b1;
        else if (rsp.ready)
            out_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_res_reg <= step_res;
    end

    assign rsp.valid          = out_vld_reg;
    assign rsp.rd_data        = out_res_reg.rd_data;
    assign rsp.mem_addr       = out_res_reg.mem_addr;
    assign rsp.disk_sector    = out_res_reg.disk_sector;
    assign rsp.disk_word      = out_res_reg.disk_word;
    assign rsp.xfer_data      = out_res_reg.xfer_data;
    assign rsp.xfer_valid     = out_res_reg.xfer_valid;
    assign rsp.xfer_to_memory = out_res_reg.xfer_to_memory;
    assign rsp.ready_res      = out_res_reg.ready_res;
    assign rsp.irq            = out_res_reg.irq;
    assign rsp.error          = out_res_reg.error;

    // A running transfer never shows the controller ready
    a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        stat.busy |-> !stat.ctl_ready)
        else $error("transfer busy while controller ready");

    // Interrupts and errors always leave the controller ready
    a_irq_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.irq || rsp.error)) |-> rsp.ready_res)
        else $error("irq or error without ready");

    // Transfer fields are zero when no word moved
    a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.xfer_valid) |-> (rsp.mem_addr == '0 && rsp.disk_sector == '0
            && rsp.disk_word == '0 && rsp.xfer_data == '0 && !rsp.xfer_to_memory))
        else $error("transfer fields set without a transfer");

    // Every processed request produces a result on the next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_vld_reg)
        else $error("processed request lost");

endmodule
